// File: sv/cpu_addressing_mode_sequencer_defines.svh
// Assertion macros shared by the addressing-mode sequencer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CPU_ADDRESSING_MODE_SEQUENCER_DEFINES_SVH
`define CPU_ADDRESSING_MODE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAMS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cams assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cams assertion failed");

`endif

// File: sv/cams_pkg.sv
// Types and constants for the addressing-mode sequencer.
// Depends on nothing; used by the step logic and the top level.
`timescale 1ns / 1ps

package cams_pkg;

  // Addressing mode codes; codes above MODE_INDY are unused.
  typedef enum logic [3:0] {
    MODE_IMPL = 4'd0,
    MODE_ACC  = 4'd1,
    MODE_IMM  = 4'd2,
    MODE_ZP   = 4'd3,
    MODE_ABS  = 4'd4,
    MODE_ZPX  = 4'd5,
    MODE_ZPY  = 4'd6,
    MODE_ABSX = 4'd7,
    MODE_ABSY = 4'd8,
    MODE_INDX = 4'd9,
    MODE_INDY = 4'd10
  } mode_e;

  localparam logic [2:0] STEP_MAX = 3'd7;

  // One bus cycle as presented to the sequencer.
  typedef struct packed {
    logic [3:0]  mode;
    logic        first_cycle;
    logic [7:0]  data_bus;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] prog_counter;
  } item_t;

  // Sequencer state carried from cycle to cycle.
  typedef struct packed {
    logic [2:0]  step_count;
    logic [8:0]  low_buffer;
    logic [7:0]  high_byte;
    logic [15:0] address_reg;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [15:0] bus_address;
    logic        read_driven;
    logic        pc_advance;
    logic        done_res;
    logic        carry_cycle;
  } res_t;

endpackage

// File: sv/cams_in_if.sv
// Input channel of the addressing-mode sequencer: valid/ready plus one bus cycle.
// Depends on nothing.
`timescale 1ns / 1ps

interface cams_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic        first_cycle;
  logic [7:0]  data_bus;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [15:0] prog_counter;

  modport source (
    output valid, mode, first_cycle, data_bus, index_x, index_y, prog_counter,
    input  ready
  );

  modport sink (
    input  valid, mode, first_cycle, data_bus, index_x, index_y, prog_counter,
    output ready
  );
endinterface

// File: sv/cams_out_if.sv
// Output channel of the addressing-mode sequencer: valid/ready plus one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface cams_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic        read_driven;
  logic        pc_advance;
  logic        done_res;
  logic        carry_cycle;

  modport source (
    output valid, bus_address, read_driven, pc_advance, done_res, carry_cycle,
    input  ready
  );

  modport sink (
    input  valid, bus_address, read_driven, pc_advance, done_res, carry_cycle,
    output ready
  );
endinterface

// File: sv/cams_step.sv
// Combinational step of the addressing-mode sequencer: next state and result
// for one bus cycle. Depends on cams_pkg.
`timescale 1ns / 1ps

module cams_step (
  input  cams_pkg::item_t  item_i,
  input  cams_pkg::state_t state_i,
  output cams_pkg::state_t state_o,
  output cams_pkg::res_t   res_o
);
  import cams_pkg::*;

  mode_e      mode;
  logic [2:0] step;
  logic [7:0] idx;
  logic [2:0] test_step;
  logic       known_mode;
  logic       skip_fixup;
  logic [3:0] step_sum;
  state_t     nxt;
  res_t       res;

  assign mode       = mode_e'(item_i.mode);
  assign known_mode = (item_i.mode <= MODE_INDY);

  // A new instruction restarts the step count before the cycle is handled.
  assign step      = item_i.first_cycle ? 3'd0 : state_i.step_count;
  assign idx       = (mode == MODE_ZPY || mode == MODE_ABSY) ? item_i.index_y
                                                             : item_i.index_x;
  assign test_step = (mode == MODE_INDY) ? 3'd3 : 3'd2;

  // Per-mode decoding of the current step.
  always_comb begin
    nxt        = state_i;
    res        = '0;
    res.done_res = 1'b1;
    skip_fixup = 1'b0;

    if (known_mode && mode != MODE_ACC && step == 3'd0) begin
      // Opcode-following byte, or a dummy read for implied mode.
      res.read_driven = 1'b1;
      nxt.address_reg = item_i.prog_counter;
      res.pc_advance  = (mode != MODE_IMPL);
      res.done_res    = (mode == MODE_IMM);
    end else begin
      case (mode)
        MODE_ACC: begin
          res.read_driven = 1'b1;
        end
        MODE_ZP: begin
          if (step == 3'd1) begin
            nxt.address_reg = {8'h00, item_i.data_bus};
          end
        end
        MODE_ABS: begin
          if (step == 3'd1) begin
            nxt.low_buffer  = {1'b0, item_i.data_bus};
            res.read_driven = 1'b1;
            res.pc_advance  = 1'b1;
            res.done_res    = 1'b0;
            nxt.address_reg = item_i.prog_counter;
          end else if (step == 3'd2) begin
            nxt.high_byte   = item_i.data_bus;
            nxt.address_reg = {item_i.data_bus, state_i.low_buffer[7:0]};
          end
        end
        MODE_ZPX, MODE_ZPY: begin
          // Indexing wraps within page zero.
          if (step == 3'd1) begin
            nxt.low_buffer = {1'b0, item_i.data_bus + idx};
            res.done_res   = 1'b0;
          end else if (step == 3'd2) begin
            nxt.address_reg = {8'h00, state_i.low_buffer[7:0]};
          end
        end
        MODE_ABSX, MODE_ABSY, MODE_INDY: begin
          if (mode == MODE_INDY && step == 3'd1) begin
            // Fetch the low pointer byte from page zero.
            nxt.low_buffer  = {1'b0, item_i.data_bus};
            res.read_driven = 1'b1;
            res.done_res    = 1'b0;
            nxt.address_reg = {8'h00, item_i.data_bus};
          end else if (step == test_step - 3'd1) begin
            // Add the index, keeping the page carry in bit 8.
            nxt.low_buffer = {1'b0, item_i.data_bus}
                           + {1'b0, (mode == MODE_INDY) ? item_i.index_y : idx};
            res.read_driven = 1'b1;
            res.done_res    = 1'b0;
            if (mode == MODE_INDY) begin
              nxt.address_reg = {8'h00, state_i.address_reg[7:0] + 8'd1};
            end else begin
              nxt.address_reg = item_i.prog_counter;
              res.pc_advance  = 1'b1;
            end
          end else if (step == test_step) begin
            // Page test: a carry costs a fix-up cycle.
            if (state_i.low_buffer[8]) begin
              nxt.low_buffer  = {1'b0, state_i.low_buffer[7:0]};
              nxt.high_byte   = item_i.data_bus + 8'd1;
              res.carry_cycle = 1'b1;
              res.done_res    = 1'b0;
            end else begin
              nxt.high_byte   = item_i.data_bus;
              nxt.address_reg = {item_i.data_bus, state_i.low_buffer[7:0]};
              skip_fixup      = 1'b1;
            end
          end else if (step == test_step + 3'd1) begin
            nxt.address_reg = {state_i.high_byte, state_i.low_buffer[7:0]};
          end
        end
        MODE_INDX: begin
          if (step == 3'd1) begin
            nxt.low_buffer = {1'b0, item_i.data_bus + item_i.index_x};
            res.done_res   = 1'b0;
          end else if (step == 3'd2) begin
            res.read_driven = 1'b1;
            res.done_res    = 1'b0;
            nxt.address_reg = {8'h00, state_i.low_buffer[7:0]};
          end else if (step == 3'd3) begin
            nxt.low_buffer  = {1'b0, item_i.data_bus};
            res.read_driven = 1'b1;
            res.done_res    = 1'b0;
            nxt.address_reg = {8'h00, state_i.address_reg[7:0] + 8'd1};
          end else if (step == 3'd4) begin
            nxt.high_byte   = item_i.data_bus;
            nxt.address_reg = {item_i.data_bus, state_i.low_buffer[7:0]};
          end
        end
        default: begin
          // Implied and immediate modes after their first step, and unused codes: nothing driven.
        end
      endcase
    end
  end

  // Step counter advances by one, or by two when the fix-up slot is skipped,
  // and saturates.
  assign step_sum = {1'b0, step} + (skip_fixup ? 4'd2 : 4'd1);

  always_comb begin
    state_o = nxt;
    state_o.step_count = step_sum[3] ? STEP_MAX : step_sum[2:0];
    res_o = res;
    res_o.bus_address = nxt.address_reg;
  end

endmodule

// File: sv/cpu_addressing_mode_sequencer.sv
// Cycle-by-cycle effective-address sequencer for the eleven addressing modes of
// an 8-bit CPU. Each input item is one bus cycle and yields exactly one result
// item. The block takes one item per clock while the output is not stalled; an
// item passes through an input register, then the result register, and the
// sequencer state is updated as the item moves from the first register to the
// second, so consecutive items see each other's effects with no bubble. A stall
// on the output holds both registers and drops input ready only when both are
// full. Depends on cams_pkg, cams_in_if, cams_out_if, cams_step and the defines
// header.
`timescale 1ns / 1ps
`include "cpu_addressing_mode_sequencer_defines.svh"

module cpu_addressing_mode_sequencer (
  input logic       clk_i,
  input logic       rst_ni,
  cams_in_if.sink   in_i,
  cams_out_if.source out_o
);
  import cams_pkg::*;

  logic   in_vld_q;
  item_t  item_q;
  item_t  item_d;
  logic   out_vld_q;
  res_t   res_q;
  res_t   res_d;
  state_t state_q;
  state_t state_d;
  logic   advance;
  logic   accept;

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied.
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign accept      = in_i.valid && in_i.ready;

  assign item_d = '{mode:         in_i.mode,
                    first_cycle:  in_i.first_cycle,
                    data_bus:     in_i.data_bus,
                    index_x:      in_i.index_x,
                    index_y:      in_i.index_y,
                    prog_counter: in_i.prog_counter};

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // Address sequencing for one bus cycle.
  cams_step u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q   <= state_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.bus_address = res_q.bus_address;
  assign out_o.read_driven = res_q.read_driven;
  assign out_o.pc_advance  = res_q.pc_advance;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.carry_cycle = res_q.carry_cycle;

  // A fix-up cycle is never the last one and issues no read.
  `CAMS_ASSERT_IMPL(a_carry_not_done, clk_i, rst_ni, out_vld_q && res_q.carry_cycle, !res_q.done_res && !res_q.read_driven)
  // Advancing PC always goes with a read.
  `CAMS_ASSERT_IMPL(a_adv_reads, clk_i, rst_ni, out_vld_q && res_q.pc_advance, res_q.read_driven)
  // Within one instruction the step count never goes back.
  `CAMS_ASSERT_NEXT(a_step_mono, clk_i, rst_ni, advance && !item_q.first_cycle, state_q.step_count >= $past(state_q.step_count))
  // The fix-up cycle leaves the bus address where it was.
  `CAMS_ASSERT_NEXT(a_carry_holds_addr, clk_i, rst_ni, advance && res_d.carry_cycle, state_q.address_reg == $past(state_q.address_reg))
  // Both registers full and stalled: no item may enter.
  `CAMS_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, in_vld_q && out_vld_q && !out_o.ready, !in_i.ready)

endmodule

// File: verif/tb_cpu_addressing_mode_sequencer.sv
// Self-checking testbench for the addressing-mode sequencer: bus cycles are queued,
// driven with random gaps and an output hold-off, and every result is compared.
// Depends on cams_pkg, cams_in_if, cams_out_if and cpu_addressing_mode_sequencer.
`timescale 1ns / 1ps

module tb_cpu_addressing_mode_sequencer;
  import cams_pkg::*;

  // Spare mode code; codes above MODE_INDY finish at once and drive nothing.
  localparam logic [3:0] MODE_SPARE = 4'd15;

  localparam int unsigned RANDOM_CYCLES  = 900;
  localparam int unsigned IDLE_PERCENT   = 16;
  localparam int unsigned QUIET_START    = 600;
  localparam int unsigned QUIET_END      = 900;
  localparam int unsigned HOLD_AFTER     = 120;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  // A predicted result, tagged with the clock count at which its bus cycle went in.
  typedef struct {
    res_t        res;
    int unsigned at_cycle;
  } predicted_cycle_t;

  logic clk_i;
  logic rst_ni;

  cams_in_if  in_if ();
  cams_out_if out_if ();

  cpu_addressing_mode_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  item_t            bus_cycles_to_send[$];
  predicted_cycle_t predicted_cycles[$];
  int unsigned      cycle_cnt = 0;
  int unsigned      results_seen = 0;
  int unsigned      fail_cnt = 0;
  int unsigned      hold_left;
  logic             hold_done;

  // Base length of a random instruction per mode, first cycle included; ABSX, ABSY and INDY count a crossing.
  int unsigned nominal_len [11] = '{1, 1, 1, 2, 3, 3, 3, 4, 4, 5, 5};

  // Sequencer state as the checker sees it.
  logic [2:0]  seq_step;
  logic [8:0]  seq_low;
  logic [7:0]  seq_high;
  logic [15:0] seq_addr;

  wire quiet_window = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_END);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Works out the result of one bus cycle and moves the sequencer state on.
  function automatic res_t predict_bus_cycle(input item_t it);
    res_t        r;
    logic [2:0]  s;
    logic [7:0]  idx;
    int unsigned page_step;
    int unsigned advance;
    r = '0;
    r.done_res = 1'b1;
    advance = 1;
    if (it.first_cycle) seq_step = '0;
    s = seq_step;
    idx = (it.mode == MODE_ZPY || it.mode == MODE_ABSY) ? it.index_y : it.index_x;
    page_step = (it.mode == MODE_INDY) ? 3 : 2;
    if (it.mode <= MODE_INDY && it.mode != MODE_ACC && s == 3'd0) begin
      // Operand fetch through PC, or a dummy read for the implied mode.
      r.read_driven = 1'b1;
      seq_addr = it.prog_counter;
      r.pc_advance = (it.mode != MODE_IMPL);
      r.done_res = (it.mode == MODE_IMM);
    end else begin
      case (it.mode)
        MODE_ACC: r.read_driven = 1'b1;
        MODE_ZP: begin
          if (s == 3'd1) seq_addr = {8'h00, it.data_bus};
        end
        MODE_ABS: begin
          if (s == 3'd1) begin
            seq_low = {1'b0, it.data_bus};
            r.read_driven = 1'b1;
            r.pc_advance = 1'b1;
            r.done_res = 1'b0;
            seq_addr = it.prog_counter;
          end else if (s == 3'd2) begin
            seq_high = it.data_bus;
            seq_addr = {seq_high, seq_low[7:0]};
          end
        end
        MODE_ZPX, MODE_ZPY: begin
          // Zero-page indexing wraps within page zero.
          if (s == 3'd1) begin
            seq_low = {1'b0, it.data_bus + idx};
            r.done_res = 1'b0;
          end else if (s == 3'd2) begin
            seq_addr = {8'h00, seq_low[7:0]};
          end
        end
        MODE_ABSX, MODE_ABSY, MODE_INDY: begin
          if (it.mode == MODE_INDY && s == 3'd1) begin
            seq_low = {1'b0, it.data_bus};
            r.read_driven = 1'b1;
            r.done_res = 1'b0;
            seq_addr = {8'h00, it.data_bus};
          end else if (int'(s) == page_step - 1) begin
            seq_low = {1'b0, it.data_bus}
                    + {1'b0, (it.mode == MODE_INDY) ? it.index_y : idx};
            r.read_driven = 1'b1;
            r.done_res = 1'b0;
            if (it.mode == MODE_INDY) begin
              seq_addr = {8'h00, seq_addr[7:0] + 8'd1};
            end else begin
              seq_addr = it.prog_counter;
              r.pc_advance = 1'b1;
            end
          end else if (int'(s) == page_step) begin
            // Page test: a carry costs a fix-up cycle, otherwise that slot is skipped.
            if (seq_low[8]) begin
              seq_low[8] = 1'b0;
              seq_high = it.data_bus + 8'd1;
              r.carry_cycle = 1'b1;
              r.done_res = 1'b0;
            end else begin
              seq_high = it.data_bus;
              seq_addr = {seq_high, seq_low[7:0]};
              advance = 2;
            end
          end else if (int'(s) == page_step + 1) begin
            seq_addr = {seq_high, seq_low[7:0]};
          end
        end
        MODE_INDX: begin
          if (s == 3'd1) begin
            seq_low = {1'b0, it.data_bus + it.index_x};
            r.done_res = 1'b0;
          end else if (s == 3'd2) begin
            r.read_driven = 1'b1;
            r.done_res = 1'b0;
            seq_addr = {8'h00, seq_low[7:0]};
          end else if (s == 3'd3) begin
            seq_low = {1'b0, it.data_bus};
            r.read_driven = 1'b1;
            r.done_res = 1'b0;
            seq_addr = {8'h00, seq_addr[7:0] + 8'd1};
          end else if (s == 3'd4) begin
            seq_high = it.data_bus;
            seq_addr = {seq_high, seq_low[7:0]};
          end
        end
        default: ;
      endcase
    end
    seq_step = (int'(s) + advance > int'(STEP_MAX)) ? STEP_MAX : 3'(int'(s) + advance);
    r.bus_address = seq_addr;
    return r;
  endfunction

  // Queues one instruction: its first cycle is marked and PC moves on each cycle.
  task automatic queue_instruction(input logic [3:0] mode, input int unsigned n_cycles,
                                   input bit rand_data, input logic [7:0] data,
                                   input logic [7:0] x, input logic [7:0] y,
                                   input logic [15:0] pc);
    item_t it;
    for (int unsigned i = 0; i < n_cycles; i++) begin
      it.mode = mode;
      it.first_cycle = (i == 0);
      it.data_bus = !rand_data ? data : ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom);
      it.index_x = x;
      it.index_y = y;
      it.prog_counter = pc + 16'(i);
      bus_cycles_to_send.push_back(it);
    end
  endtask

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sender: offers queued bus cycles and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bus_cycles
    item_t taken;
    item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode <= MODE_IMPL;
      in_if.first_cycle <= 1'b0;
      in_if.data_bus <= '0;
      in_if.index_x <= '0;
      in_if.index_y <= '0;
      in_if.prog_counter <= '0;
      seq_step = '0;
      seq_low = '0;
      seq_high = '0;
      seq_addr = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.mode = in_if.mode;
        taken.first_cycle = in_if.first_cycle;
        taken.data_bus = in_if.data_bus;
        taken.index_x = in_if.index_x;
        taken.index_y = in_if.index_y;
        taken.prog_counter = in_if.prog_counter;
        predicted_cycles.push_back('{predict_bus_cycle(taken), cycle_cnt});
      end
      if (!in_if.valid || in_if.ready) begin
        if (bus_cycles_to_send.size() != 0 &&
            (quiet_window || $urandom_range(99) >= IDLE_PERCENT)) begin
          nxt = bus_cycles_to_send.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode <= nxt.mode;
          in_if.first_cycle <= nxt.first_cycle;
          in_if.data_bus <= nxt.data_bus;
          in_if.index_x <= nxt.index_x;
          in_if.index_y <= nxt.index_y;
          in_if.prog_counter <= nxt.prog_counter;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and applies back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    predicted_cycle_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        // A prediction made at this very edge cannot belong to this result.
        if (predicted_cycles.size() == 0 || predicted_cycles[0].at_cycle == cycle_cnt) begin
          $error("unexpected result: bus_address %h", out_if.bus_address);
          fail_cnt++;
        end else begin
          want = predicted_cycles.pop_front();
          if (out_if.bus_address !== want.res.bus_address) begin
            $error("bus_address: expected %h, got %h", want.res.bus_address,
                   out_if.bus_address);
            fail_cnt++;
          end
          if (out_if.read_driven !== want.res.read_driven) begin
            $error("read_driven: expected %b, got %b", want.res.read_driven,
                   out_if.read_driven);
            fail_cnt++;
          end
          if (out_if.pc_advance !== want.res.pc_advance) begin
            $error("pc_advance: expected %b, got %b", want.res.pc_advance,
                   out_if.pc_advance);
            fail_cnt++;
          end
          if (out_if.done_res !== want.res.done_res) begin
            $error("done_res: expected %b, got %b", want.res.done_res, out_if.done_res);
            fail_cnt++;
          end
          if (out_if.carry_cycle !== want.res.carry_cycle) begin
            $error("carry_cycle: expected %b, got %b", want.res.carry_cycle,
                   out_if.carry_cycle);
            fail_cnt++;
          end
        end
      end
      // One long hold-off lets the block fill and stall its input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet_window || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned m;
    rst_ni = 1'b0;

    // Directed: every mode but ZP and ZPY once, plus a spare code, with wraps, a page crossing and a skipped fix-up.
    queue_instruction(MODE_IMPL, 2, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
    queue_instruction(MODE_ACC, 1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    queue_instruction(MODE_IMM, 1, 1'b0, 8'h5A, 8'h00, 8'h00, 16'h8000);
    queue_instruction(MODE_ZPX, 3, 1'b0, 8'hFF, 8'hFF, 8'h00, 16'h0200);
    queue_instruction(MODE_ABS, 3, 1'b0, 8'hFF, 8'h00, 8'h00, 16'hFFFF);
    queue_instruction(MODE_ABSX, 4, 1'b0, 8'hFF, 8'hFF, 8'h00, 16'h1234);
    queue_instruction(MODE_ABSY, 3, 1'b0, 8'h00, 8'h00, 8'h00, 16'h4321);
    queue_instruction(MODE_INDX, 5, 1'b0, 8'hFF, 8'h01, 8'h00, 16'hC000);
    queue_instruction(MODE_INDY, 5, 1'b0, 8'hFF, 8'h00, 8'hFF, 16'h00FF);
    queue_instruction(MODE_SPARE, 1, 1'b0, 8'hAA, 8'h55, 8'hAA, 16'h5555);

    // Random: mostly whole instructions with random content, some loose cycles.
    while (bus_cycles_to_send.size() < RANDOM_CYCLES) begin
      if ($urandom_range(99) < 80) begin
        m = $urandom_range(int'(MODE_INDY));
        queue_instruction(4'(m), nominal_len[m] + $urandom_range(2), 1'b1, 8'h00,
                          8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          bus_cycles_to_send.push_back('{4'($urandom_range(15)), 1'($urandom),
                                         8'($urandom), 8'($urandom), 8'($urandom),
                                         16'($urandom)});
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bus_cycles_to_send.size() != 0 || in_if.valid) @(posedge clk_i);
    while (predicted_cycles.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
